>>> rtl/host_port_endpoint_parser_macros.svh
// Assertion helpers for the endpoint parser.
`ifndef HOST_PORT_ENDPOINT_PARSER_MACROS_SVH
`define HOST_PORT_ENDPOINT_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define HPEP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HPEP_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `HPEP_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define HPEP_ASSERT(lbl, clk, rstn, prop, msg)
`define HPEP_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

>>> rtl/hpep_pkg.sv
package hpep_pkg;

  localparam int unsigned HOST_CAP_DEF = 64;
  localparam int unsigned PORT_W       = 16;
  localparam int unsigned HL_W         = 6;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_DIGIT0   = 8'h30;
  localparam logic [7:0] CH_DIGIT9   = 8'h39;

  localparam logic [19:0] PORT_MAX = 20'd65535;

  typedef enum logic [2:0] {
    PH_START,
    PH_PLAIN,
    PH_BR_HOST,
    PH_BR_CLOSED,
    PH_BR_PORT,
    PH_BR_BAD
  } phase_e;

  typedef struct packed {
    logic              ok;
    logic              has_port;
    logic [PORT_W-1:0] port_number;
    logic              host_offset;
    logic [HL_W-1:0]   host_length;
  } verdict_t;

endpackage

>>> rtl/host_port_endpoint_parser.sv
// Endpoint text parser, one byte per item.
// out_valid_o rises once the byte marked last has left the input register and its verdict is loaded into res_q.
// Throughput: 1 byte per cycle while no verdict waits; the parse state steps on each byte taken.
// A waiting verdict stalls only the next last byte; bytes before it keep flowing, later ones wait.
// Reset (rst_ni low, async): valids cleared, parser at start of text.
`include "host_port_endpoint_parser_macros.svh"

module host_port_endpoint_parser
  import hpep_pkg::*;
#(
  parameter int unsigned HOST_CAP = HOST_CAP_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic              has_port_o,
  output logic [PORT_W-1:0] port_number_o,
  output logic              host_offset_o,
  output logic [HL_W-1:0]   host_length_o
);

  logic       s_valid;
  logic [7:0] s_ch;
  logic       s_last;
  logic       advance;
  logic       load;
  verdict_t   verdict;
  verdict_t   res_q;
  logic       out_valid_q, out_valid_d;
  logic       res_dirty;

  assign advance = s_valid && (!s_last || !out_valid_q || out_ready_i);
  assign load    = advance && s_last;

  hpep_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .advance_i  (advance),
    .valid_o    (s_valid),
    .ch_o       (s_ch),
    .last_o     (s_last)
  );

  hpep_parse #(
    .HOST_CAP (HOST_CAP)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .ch_i      (s_ch),
    .last_i    (s_last),
    .verdict_o (verdict)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= verdict;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = res_q.ok;
  assign has_port_o    = res_q.has_port;
  assign port_number_o = res_q.port_number;
  assign host_offset_o = res_q.host_offset;
  assign host_length_o = res_q.host_length;

  assign res_dirty = has_port_o || (port_number_o != '0) || host_offset_o ||
                     (host_length_o != '0);

  `HPEP_ASSERT(a_load_shows, clk_i, rst_ni, load |=> out_valid_o, "verdict lost after load")
  `HPEP_ASSERT_NEVER(a_fail_zero, clk_i, rst_ni, out_valid_o && !ok_o && res_dirty, "fail not zero")
  `HPEP_ASSERT_NEVER(a_port_nonzero, clk_i, rst_ni, out_valid_o && has_port_o && port_number_o == '0, "zero port")
  `HPEP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, load && out_valid_q && !out_ready_i, "overwrite")

endmodule

>>> rtl/hpep_in_reg.sv
module hpep_in_reg
  import hpep_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] ch_o,
  output logic       last_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] ch_q;
  logic       last_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign last_o  = last_q;

endmodule

>>> rtl/hpep_parse.sv
module hpep_parse
  import hpep_pkg::*;
#(
  parameter int unsigned HOST_CAP = HOST_CAP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output verdict_t   verdict_o
);

  localparam int unsigned CNT_W = $clog2(HOST_CAP + 1);
  localparam int unsigned EXT_W = (CNT_W > HL_W) ? CNT_W : HL_W;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(HOST_CAP);

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  cpos_q, cpos_d;
  logic [1:0]        ccnt_q, ccnt_d;
  logic [PORT_W-1:0] acc_q, acc_d;
  logic              seen_q, seen_d;
  logic              inv_q, inv_d;
  logic              ended_q, ended_d;

  logic              plain_byte;
  logic              port_byte;
  logic              is_digit;
  logic [3:0]        digit;
  logic [19:0]       acc_next;
  logic [CNT_W-1:0]  total_inc;
  logic [CNT_W-1:0]  host;
  logic [EXT_W-1:0]  host_ext;
  logic              port_good;
  logic              ok;
  logic              has_port;
  logic              offset;

  assign is_digit  = (ch_i >= CH_DIGIT0) && (ch_i <= CH_DIGIT9);
  assign digit     = 4'((ch_i - CH_DIGIT0) & 8'h0F);
  assign acc_next  = 20'({acc_q, 3'b000}) + 20'({acc_q, 1'b0}) + 20'(digit);
  assign total_inc = (total_q < CAP) ? total_q + 1'b1 : CAP;

  always_comb begin
    phase_d    = phase_q;
    total_d    = total_q;
    cpos_d     = cpos_q;
    ccnt_d     = ccnt_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    inv_d      = inv_q;
    ended_d    = ended_q;
    plain_byte = 1'b0;
    port_byte  = 1'b0;

    if (!ended_q) begin
      if (ch_i == CH_NUL) begin
        ended_d = 1'b1;
      end else begin
        case (phase_q)
          PH_START: begin
            if (ch_i == CH_LBRACKET) begin
              phase_d = PH_BR_HOST;
            end else begin
              phase_d    = PH_PLAIN;
              plain_byte = 1'b1;
            end
          end
          PH_PLAIN: plain_byte = 1'b1;
          PH_BR_HOST: begin
            if (ch_i == CH_RBRACKET) begin
              phase_d = PH_BR_CLOSED;
            end else begin
              total_d = total_inc;
            end
          end
          PH_BR_CLOSED: phase_d = (ch_i == CH_COLON) ? PH_BR_PORT : PH_BR_BAD;
          PH_BR_PORT:   port_byte = 1'b1;
          default: ;
        endcase
      end
    end

    if (plain_byte) begin
      if (ch_i == CH_COLON) begin
        if (ccnt_q == 2'd0) begin
          cpos_d = total_q;
          ccnt_d = 2'd1;
        end else begin
          ccnt_d = 2'd2;
        end
      end else if (ccnt_q == 2'd1) begin
        port_byte = 1'b1;
      end
      total_d = total_inc;
    end

    if (port_byte) begin
      if (is_digit) begin
        seen_d = 1'b1;
        if (!inv_q) begin
          if (acc_next > PORT_MAX) begin
            inv_d = 1'b1;
          end else begin
            acc_d = acc_next[PORT_W-1:0];
          end
        end
      end else begin
        inv_d = 1'b1;
      end
    end
  end

  // verdict from the state as it stands after this byte
  always_comb begin
    ok        = 1'b0;
    has_port  = 1'b0;
    offset    = 1'b0;
    host      = '0;
    port_good = seen_d && !inv_d && (acc_d != '0);
    case (phase_d)
      PH_PLAIN: begin
        if (ccnt_d == 2'd1) begin
          host     = cpos_d;
          has_port = 1'b1;
          ok       = (cpos_d != '0) && port_good;
        end else begin
          host = total_d;
          ok   = (total_d != '0);
        end
      end
      PH_BR_CLOSED, PH_BR_PORT: begin
        host     = total_d;
        offset   = 1'b1;
        has_port = (phase_d == PH_BR_PORT);
        ok       = (total_d != '0) && (!has_port || port_good);
      end
      default: ;
    endcase
    if (host >= CAP) begin
      ok = 1'b0;
    end
  end

  assign host_ext = EXT_W'(host);

  always_comb begin
    verdict_o = '0;
    if (ok) begin
      verdict_o.ok          = 1'b1;
      verdict_o.has_port    = has_port;
      verdict_o.port_number = has_port ? acc_d : '0;
      verdict_o.host_offset = offset;
      verdict_o.host_length = host_ext[HL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      total_q <= '0;
      cpos_q  <= '0;
      ccnt_q  <= '0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      inv_q   <= 1'b0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_START;
        total_q <= '0;
        cpos_q  <= '0;
        ccnt_q  <= '0;
        acc_q   <= '0;
        seen_q  <= 1'b0;
        inv_q   <= 1'b0;
        ended_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        total_q <= total_d;
        cpos_q  <= cpos_d;
        ccnt_q  <= ccnt_d;
        acc_q   <= acc_d;
        seen_q  <= seen_d;
        inv_q   <= inv_d;
        ended_q <= ended_d;
      end
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import hpep_pkg::*;

  localparam int unsigned HCAP      = HOST_CAP_DEF;
  localparam int unsigned QUIET_MAX = 4000;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned DRAIN     = 16;
  localparam int unsigned N_BYTES   = 2000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        ch_i;
  logic              last_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              ok_o;
  logic              has_port_o;
  logic [PORT_W-1:0] port_number_o;
  logic              host_offset_o;
  logic [HL_W-1:0]   host_length_o;

  class endpoint_scoreboard;
    phase_e      ph;
    logic [6:0]  host_cnt;
    logic [6:0]  colon_at;
    logic [1:0]  n_colons;
    logic [16:0] port_acc;
    bit          digit_seen;
    bit          port_bad;
    bit          ended;
    verdict_t    expected_q[$];
    int unsigned mismatches, verdicts, ok_cnt, port_cnt, bracket_cnt;

    function new();
      clear();
    endfunction

    function void clear();
      ph         = PH_START;
      host_cnt   = '0;
      colon_at   = '0;
      n_colons   = '0;
      port_acc   = '0;
      digit_seen = 1'b0;
      port_bad   = 1'b0;
      ended      = 1'b0;
    endfunction

    function logic [6:0] bump(logic [6:0] v);
      return (v < HCAP) ? v + 7'd1 : 7'(HCAP);
    endfunction

    function void port_byte(logic [7:0] c);
      int unsigned v;
      if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
        digit_seen = 1'b1;
        if (!port_bad) begin
          v = port_acc * 10 + (c - CH_DIGIT0);
          if (v > PORT_MAX) port_bad = 1'b1;
          else port_acc = v[16:0];
        end
      end else begin
        port_bad = 1'b1;
      end
    endfunction

    function void plain_byte(logic [7:0] c);
      if (c == CH_COLON) begin
        if (n_colons == 2'd0) begin
          colon_at = host_cnt;
          n_colons = 2'd1;
        end else begin
          n_colons = 2'd2;
        end
      end else if (n_colons == 2'd1) begin
        port_byte(c);
      end
      host_cnt = bump(host_cnt);
    endfunction

    function void note_byte(logic [7:0] c, logic l);
      verdict_t   v;
      logic [6:0] host;
      bit         good, with_port, br, port_ok;
      if (!ended) begin
        if (c == CH_NUL) begin
          ended = 1'b1;
        end else begin
          case (ph)
            PH_START: begin
              if (c == CH_LBRACKET) ph = PH_BR_HOST;
              else begin
                ph = PH_PLAIN;
                plain_byte(c);
              end
            end
            PH_PLAIN: plain_byte(c);
            PH_BR_HOST: begin
              if (c == CH_RBRACKET) ph = PH_BR_CLOSED;
              else host_cnt = bump(host_cnt);
            end
            PH_BR_CLOSED: ph = (c == CH_COLON) ? PH_BR_PORT : PH_BR_BAD;
            PH_BR_PORT: port_byte(c);
            default: ;
          endcase
        end
      end
      if (l) begin
        v         = '0;
        host      = '0;
        good      = 1'b0;
        with_port = 1'b0;
        br        = 1'b0;
        port_ok   = digit_seen && !port_bad && port_acc != 0;
        if (ph == PH_PLAIN) begin
          if (n_colons == 2'd1) begin
            host      = colon_at;
            with_port = 1'b1;
            good      = host != 0 && port_ok;
          end else begin
            host = host_cnt;
            good = host != 0;
          end
        end else if (ph == PH_BR_CLOSED || ph == PH_BR_PORT) begin
          host      = host_cnt;
          br        = 1'b1;
          with_port = (ph == PH_BR_PORT);
          good      = host != 0 && (!with_port || port_ok);
        end
        if (host >= HCAP) good = 1'b0;
        if (good) begin
          v.ok          = 1'b1;
          v.has_port    = with_port;
          v.port_number = with_port ? port_acc[15:0] : '0;
          v.host_offset = br;
          v.host_length = host[HL_W-1:0];
        end
        expected_q.push_back(v);
        clear();
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t exp;
      if (expected_q.size() == 0) begin
        flag($sformatf("verdict with none pending: %p", got));
        return;
      end
      exp = expected_q.pop_front();
      verdicts++;
      ok_cnt      += exp.ok;
      port_cnt    += exp.has_port;
      bracket_cnt += exp.host_offset;
      if (got.ok !== exp.ok || got.has_port !== exp.has_port ||
          got.port_number !== exp.port_number || got.host_offset !== exp.host_offset ||
          got.host_length !== exp.host_length)
        flag($sformatf({"verdict %0d: exp ok=%b port?=%b port=%0d off=%b len=%0d, ",
                        "got ok=%b port?=%b port=%0d off=%b len=%0d"},
                       verdicts, exp.ok, exp.has_port, exp.port_number, exp.host_offset,
                       exp.host_length, got.ok, got.has_port, got.port_number,
                       got.host_offset, got.host_length));
    endfunction
  endclass

  endpoint_scoreboard sb = new();

  logic [7:0]  txt[$];
  int unsigned n_bytes, n_texts, quiet;
  bit          calm, hold_req, held;

  host_port_endpoint_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ch_i          (ch_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .has_port_o    (has_port_o),
    .port_number_o (port_number_o),
    .host_offset_o (host_offset_o),
    .host_length_o (host_length_o)
  );

  always #4ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_verdict({ok_o, has_port_o, port_number_o, host_offset_o, host_length_o});
      if (in_valid_i && in_ready_o) sb.note_byte(ch_i, last_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QUIET_MAX) begin
        $display("no handshake for %0d cycles, %0d verdicts pending", QUIET_MAX,
                 sb.expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: random backpressure plus one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(0, 99) >= 36;
      end
    end
  end

  task automatic send_byte(logic [7:0] c, logic l);
    if (!calm) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text();
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    n_bytes += txt.size();
    n_texts++;
    txt.delete();
  endtask

  function automatic void add_str(string s);
    foreach (s[i]) txt.push_back(s[i]);
  endfunction

  function automatic int unsigned rand_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 3) return $urandom_range(55, 70);
    if (k < 8) return 0;
    return $urandom_range(1, 12);
  endfunction

  // bracketed hosts may hold colons; nothing may hold the closing bracket or NUL
  function automatic void add_host(int unsigned n, bit br);
    string      pool;
    logic [7:0] c;
    pool = "abcdefghijklmnopqrstuvwxyz0123456789.-";
    repeat (n) begin
      if (br && $urandom_range(0, 4) == 0) begin
        c = CH_COLON;
      end else if ($urandom_range(0, 4) == 0) begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_COLON || c == CH_LBRACKET || c == CH_RBRACKET);
      end else begin
        c = pool[$urandom_range(0, pool.len() - 1)];
      end
      txt.push_back(c);
    end
  endfunction

  function automatic void add_port();
    case ($urandom_range(0, 9))
      0: ;
      1: add_str("0");
      2: add_str($sformatf("%0d", $urandom_range(65536, 9999999)));
      3: add_str($sformatf("000%0d", $urandom_range(1, 65535)));
      4: add_str($urandom_range(0, 1) ? "65535" : "65536");
      default: add_str($sformatf("%0d", $urandom_range(1, 65535)));
    endcase
  endfunction

  task automatic build_random();
    int unsigned k, pos;
    k = $urandom_range(0, 99);
    if (k < 28) begin
      add_host(rand_len(), 1'b0);
    end else if (k < 52) begin
      add_host(rand_len(), 1'b0);
      txt.push_back(CH_COLON);
      add_port();
    end else if (k < 74) begin
      txt.push_back(CH_LBRACKET);
      add_host(rand_len(), 1'b1);
      txt.push_back(CH_RBRACKET);
      if ($urandom_range(0, 1)) begin
        txt.push_back(CH_COLON);
        add_port();
      end
    end else if (k < 84) begin
      repeat ($urandom_range(2, 4)) begin
        add_host($urandom_range(0, 4), 1'b0);
        txt.push_back(CH_COLON);
      end
      if ($urandom_range(0, 1)) add_port();
      else add_host($urandom_range(0, 4), 1'b0);
    end else begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
    end
    if (k < 84 && $urandom_range(0, 99) < 15 && txt.size() > 0) begin
      pos = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 2))
        0: txt[pos] = 8'($urandom_range(0, 255));
        1: txt.insert(pos, CH_NUL);
        default: txt.delete(pos);
      endcase
    end
    if (txt.size() == 0) txt.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    string plain_cases[$];
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    ch_i       <= CH_NUL;
    last_i     <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plain_cases = '{"a", "host:80", "h:65535", "h:65536", "h:0", "h:", ":80",
                    "a:b:c", "[::1]", "[::1]:443", "[]", "[ab", "[ab]x", "[ab]:",
                    "h:8a", "h:00080", "[a]:99999", "h:123456789", "["};
    foreach (plain_cases[i]) begin
      add_str(plain_cases[i]);
      send_text();
    end
    // NUL ends the text early; bytes after it are ignored
    add_str("a:1");
    txt.push_back(CH_NUL);
    add_str("x]");
    send_text();
    txt.push_back(CH_NUL);
    send_text();
    txt.push_back(8'hFF);
    send_text();
    // host length around the cap, both forms
    add_host(HCAP - 1, 1'b0);
    send_text();
    add_host(HCAP, 1'b0);
    send_text();
    add_host(HCAP + 6, 1'b0);
    add_str(":80");
    send_text();
    txt.push_back(CH_LBRACKET);
    add_host(HCAP - 1, 1'b1);
    txt.push_back(CH_RBRACKET);
    add_str(":65535");
    send_text();
    txt.push_back(CH_LBRACKET);
    add_host(HCAP, 1'b1);
    txt.push_back(CH_RBRACKET);
    send_text();

    while (n_bytes < N_BYTES) begin
      calm = n_bytes >= 600 && n_bytes < 900;
      if (!held && n_bytes >= 1200) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      build_random();
      send_text();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("%0d texts in %0d bytes gave %0d verdicts:", n_texts, n_bytes, sb.verdicts);
    $display("  %0d accepted, %0d with port, %0d bracketed",
             sb.ok_cnt, sb.port_cnt, sb.bracket_cnt);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
